FILE: rtl/kntok_pkg.sv
// kntok_pkg: shared types, constants and character class helpers for the
// keyword/number tokenizer. No dependencies; used by every rtl file.

package kntok_pkg;

    // word buffer depth for keyword compare, and width of the position counters
    localparam int KEYWORD_CHARS  = 6;
    localparam int POSITION_WIDTH = 16;

    // fixed field widths of one result beat
    localparam int FIELD_W   = 16;
    localparam int WORD_LEN_W = $clog2(KEYWORD_CHARS + 2);

    // output queue, depth must be a power of two and at least two
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_IDX_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // keyword table
    localparam int KW_COUNT   = 10;
    localparam int KW_MAX_LEN = 6;

    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_POINT      = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_NUL        = 8'h00;

    typedef logic [POSITION_WIDTH-1:0]   pos_t;
    typedef logic [WORD_LEN_W-1:0]       word_len_t;
    typedef logic [KEYWORD_CHARS-1:0][7:0] word_buf_t;

    typedef enum logic [3:0] {
        TK_EOF      = 4'd0,
        TK_ERROR    = 4'd1,
        TK_IDENT    = 4'd2,
        TK_NUMBER   = 4'd3,
        TK_DEF      = 4'd4,
        TK_EXTERN   = 4'd5,
        TK_IF       = 4'd6,
        TK_THEN     = 4'd7,
        TK_ELSE     = 4'd8,
        TK_FOR      = 4'd9,
        TK_IN       = 4'd10,
        TK_BINARY   = 4'd11,
        TK_UNARY    = 4'd12,
        TK_LET      = 4'd13,
        TK_OPERATOR = 4'd14
    } tok_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_WORD      = 3'd1,
        MODE_NUM_DIGIT = 3'd2,
        MODE_NUM_POINT = 3'd3,
        MODE_COMMENT   = 3'd4
    } lex_mode_t;

    typedef struct packed {
        tok_kind_t          kind;
        logic [7:0]         op_char;
        logic [FIELD_W-1:0] line;
        logic [FIELD_W-1:0] column;
        logic               last;
    } tok_res_t;

    // up to two results per input beat, r0 first
    typedef struct packed {
        logic [1:0] n;
        tok_res_t   r0;
        tok_res_t   r1;
    } tok_push_t;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{"d", "e", "f", CH_NUL, CH_NUL, CH_NUL},
        '{"e", "x", "t", "e", "r", "n"},
        '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"t", "h", "e", "n", CH_NUL, CH_NUL},
        '{"e", "l", "s", "e", CH_NUL, CH_NUL},
        '{"f", "o", "r", CH_NUL, CH_NUL, CH_NUL},
        '{"i", "n", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"b", "i", "n", "a", "r", "y"},
        '{"u", "n", "a", "r", "y", CH_NUL},
        '{"l", "e", "t", CH_NUL, CH_NUL, CH_NUL}
    };
    localparam int KW_LEN [KW_COUNT] = '{3, 6, 2, 4, 4, 3, 2, 6, 5, 3};
    localparam tok_kind_t KW_KIND [KW_COUNT] = '{
        TK_DEF, TK_EXTERN, TK_IF, TK_THEN, TK_ELSE,
        TK_FOR, TK_IN, TK_BINARY, TK_UNARY, TK_LET
    };

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return is_letter(c) || c == CH_UNDERSCORE || c == CH_DOLLAR;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // parallel compare of the word buffer against all keywords
    function automatic tok_kind_t word_kind(input word_buf_t wbuf, input word_len_t wlen);
        tok_kind_t kind;
        logic      hit;
        kind = TK_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit = (wlen == WORD_LEN_W'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if (i < KW_LEN[k] && wbuf[i] != KW_TEXT[k][i]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                kind = KW_KIND[k];
            end
        end
        return kind;
    endfunction

    function automatic tok_res_t make_res(input tok_kind_t kind, input logic [7:0] op_char,
                                          input pos_t line, input pos_t column);
        tok_res_t r;
        r.kind    = kind;
        r.op_char = op_char;
        r.line    = FIELD_W'(line);
        r.column  = FIELD_W'(column);
        r.last    = 1'b0;
        return r;
    endfunction

endpackage

FILE: rtl/kntok_lexer.sv
// kntok_lexer: lexer state, position counters and keyword buffer; turns one
// input beat into up to two results combinationally. Depends on kntok_pkg.

module kntok_lexer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic [7:0]         ch,
    input  logic               eoi,
    output kntok_pkg::tok_push_t push
);
    import kntok_pkg::*;

    lex_mode_t mode_reg, mode_next;
    logic      point_seen_reg, point_seen_next;
    logic      dap_reg, dap_next;
    word_buf_t wbuf_reg;
    word_len_t wlen_reg, wlen_next;
    pos_t      line_reg, line_next;
    pos_t      col_reg, col_next;
    pos_t      tline_reg, tline_next;
    pos_t      tcol_reg, tcol_next;

    logic      wr_en;
    word_len_t wr_sel;
    logic      is_nl;
    pos_t      line_adv, col_adv;
    logic      do_start;
    logic      emit_a, emit_b;
    tok_res_t  res_a, res_b;
    tok_res_t  out0, out1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            point_seen_reg <= 1'b0;
            dap_reg        <= 1'b0;
            wlen_reg       <= '0;
            line_reg       <= pos_t'(1);
            col_reg        <= '0;
            tline_reg      <= pos_t'(1);
            tcol_reg       <= '0;
        end else if (advance) begin
            mode_reg       <= mode_next;
            point_seen_reg <= point_seen_next;
            dap_reg        <= dap_next;
            wlen_reg       <= wlen_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            tline_reg      <= tline_next;
            tcol_reg       <= tcol_next;
        end
    end

    // word buffer, no reset: only entries below the word length are compared
    always_ff @(posedge aclk) begin
        for (int i = 0; i < KEYWORD_CHARS; i++) begin
            if (advance && wr_en && wr_sel == WORD_LEN_W'(i)) begin
                wbuf_reg[i] <= ch;
            end
        end
    end

    always_comb begin
        is_nl    = (ch == CH_LF) || (ch == CH_CR);
        line_adv = line_reg;
        col_adv  = col_reg;
        if (is_nl) begin
            if (line_reg != {POSITION_WIDTH{1'b1}}) begin
                line_adv = line_reg + pos_t'(1);
            end
            col_adv = '0;
        end else if (col_reg != {POSITION_WIDTH{1'b1}}) begin
            col_adv = col_reg + pos_t'(1);
        end

        mode_next       = mode_reg;
        point_seen_next = point_seen_reg;
        dap_next        = dap_reg;
        wlen_next       = wlen_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        tline_next      = tline_reg;
        tcol_next       = tcol_reg;
        wr_en           = 1'b0;
        wr_sel          = '0;
        do_start        = 1'b0;
        emit_a          = 1'b0;
        emit_b          = 1'b0;
        res_a           = '0;
        res_b           = '0;

        if (eoi) begin
            // flush pending token, then eof at the unmoved position
            unique case (mode_reg)
                MODE_WORD: begin
                    emit_a = 1'b1;
                    res_a  = make_res(word_kind(wbuf_reg, wlen_reg), CH_NUL, tline_reg, tcol_reg);
                end
                MODE_NUM_DIGIT: begin
                    emit_a = 1'b1;
                    res_a  = make_res(TK_NUMBER, CH_NUL, tline_reg, tcol_reg);
                end
                MODE_NUM_POINT: begin
                    emit_a = 1'b1;
                    res_a  = make_res(dap_reg ? TK_NUMBER : TK_ERROR, CH_NUL,
                                      tline_reg, tcol_reg);
                end
                default: ;
            endcase
            emit_b    = 1'b1;
            res_b     = make_res(TK_EOF, CH_NUL, line_reg, col_reg);
            mode_next = MODE_IDLE;
        end else begin
            line_next = line_adv;
            col_next  = col_adv;
            unique case (mode_reg)
                MODE_COMMENT: begin
                    if (is_nl) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_WORD: begin
                    if (is_word_start(ch) || is_digit(ch)) begin
                        wr_en  = (wlen_reg < WORD_LEN_W'(KEYWORD_CHARS));
                        wr_sel = wlen_reg;
                        if (wlen_reg <= WORD_LEN_W'(KEYWORD_CHARS)) begin
                            wlen_next = wlen_reg + WORD_LEN_W'(1);
                        end
                    end else begin
                        emit_a   = 1'b1;
                        res_a    = make_res(word_kind(wbuf_reg, wlen_reg), CH_NUL,
                                            tline_reg, tcol_reg);
                        do_start = 1'b1;
                    end
                end
                MODE_NUM_DIGIT: begin
                    if (is_digit(ch)) begin
                        if (point_seen_reg) begin
                            dap_next = 1'b1;
                        end
                    end else if (ch == CH_POINT && !point_seen_reg) begin
                        point_seen_next = 1'b1;
                    end else begin
                        emit_a = 1'b1;
                        // second point or letter glued to the number
                        if (ch == CH_POINT || is_letter(ch)) begin
                            res_a = make_res(TK_ERROR, CH_NUL, line_adv, col_adv);
                        end else begin
                            res_a = make_res(TK_NUMBER, CH_NUL, tline_reg, tcol_reg);
                        end
                        do_start = 1'b1;
                    end
                end
                MODE_NUM_POINT: begin
                    if (is_digit(ch)) begin
                        dap_next = 1'b1;
                    end else begin
                        emit_a = 1'b1;
                        if (is_letter(ch)) begin
                            res_a = make_res(TK_ERROR, CH_NUL, line_adv, col_adv);
                        end else begin
                            res_a = make_res(dap_reg ? TK_NUMBER : TK_ERROR, CH_NUL,
                                             tline_reg, tcol_reg);
                        end
                        do_start = 1'b1;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            // character as first of a new token
            if (do_start) begin
                mode_next = MODE_IDLE;
                if (!is_space(ch)) begin
                    tline_next = line_adv;
                    tcol_next  = col_adv;
                    if (is_word_start(ch)) begin
                        mode_next = MODE_WORD;
                        wr_en     = 1'b1;
                        wr_sel    = '0;
                        wlen_next = WORD_LEN_W'(1);
                    end else if (is_digit(ch)) begin
                        mode_next       = MODE_NUM_DIGIT;
                        point_seen_next = 1'b0;
                        dap_next        = 1'b0;
                    end else if (ch == CH_POINT) begin
                        mode_next       = MODE_NUM_POINT;
                        point_seen_next = 1'b1;
                        dap_next        = 1'b0;
                    end else if (ch == CH_HASH) begin
                        mode_next = MODE_COMMENT;
                    end else begin
                        emit_b = 1'b1;
                        res_b  = make_res(TK_OPERATOR, ch, line_adv, col_adv);
                    end
                end
            end
        end

        out0      = emit_a ? res_a : res_b;
        out0.last = !(emit_a && emit_b);
        out1      = res_b;
        out1.last = 1'b1;
        push.r0   = out0;
        push.r1   = out1;
        push.n    = advance ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
    end

endmodule

FILE: rtl/kntok_outq.sv
// kntok_outq: small result queue that takes up to two results per cycle and
// hands out one per beat on the master side. Depends on kntok_pkg.

module kntok_outq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  kntok_pkg::tok_push_t   push,
    input  logic                   out_ready,
    output logic                   out_valid,
    output kntok_pkg::tok_res_t    out_res,
    output logic                   room
);
    import kntok_pkg::*;

    tok_res_t                q_mem [OUTQ_DEPTH];
    logic [OUTQ_IDX_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [OUTQ_CNT_W-1:0]   count_reg;
    logic                    pop;

    assign out_valid = (count_reg != '0);
    assign out_res   = q_mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a full two-result beat
    assign room      = (count_reg <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            q_mem[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            q_mem[wr_ptr_reg + OUTQ_IDX_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + OUTQ_IDX_W'(push.n);
            rd_ptr_reg <= rd_ptr_reg + OUTQ_IDX_W'(pop);
            count_reg  <= count_reg + OUTQ_CNT_W'(push.n) - OUTQ_CNT_W'(pop);
        end
    end

endmodule

FILE: rtl/keyword_number_tokenizer_unit.sv
// keyword_number_tokenizer_unit: top level of the streaming tokenizer, input
// register plus kntok_lexer and kntok_outq. Depends on kntok_pkg.
//
// usage
//   slave side: one beat per source character, s_tdata = char_code,
//   s_tuser = end_of_input (char ignored); a beat is taken when
//   s_tvalid and s_tready are both high
//   master side: one beat per token, m_tuser = token_kind,
//   m_tdata = {start_column, start_line, operator_char}, m_tlast marks
//   the final token caused by one input beat; an end mark always yields
//   at least the eof token
//   path: a taken input beat waits in the input register, then the lexer
//   writes its results straight into the queue once the queue has room
//   throughput: one input beat per cycle as long as each beat yields at
//   most one token and m_tready stays high; a beat that yields two tokens
//   costs one more master beat, the master side moving one token per cycle
//   s_tready is set by the input register and the fill of the 4-entry
//   result queue, which must hold room for two results
//   reset: aresetn low clears the lexer to idle, line 1 column 0, and
//   empties the queue; the keyword buffer is not cleared
//   stall: with m_tready low the queue fills, then the input register
//   holds its beat and s_tready drops; nothing is lost or repeated

module keyword_number_tokenizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] operator_char, [23:8] start_line,
                                   // [39:24] start_column
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast    // last token of the input beat
);
    import kntok_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_eoi_reg;

    logic       advance;
    logic       room;
    tok_push_t  push;
    tok_res_t   out_res;

    // lexer steps when a beat is held and the queue can take two results
    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_eoi_reg  <= s_tuser;
        end
    end

    kntok_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .ch      (in_char_reg),
        .eoi     (in_eoi_reg),
        .push    (push)
    );

    kntok_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .room      (room)
    );

    // pack result beat
    assign m_tuser = out_res.kind;
    assign m_tdata = {out_res.column, out_res.line, out_res.op_char};
    assign m_tlast = out_res.last;

endmodule

FILE: rtl/kntok_checker.sv
// kntok_checker: port-level checks on the tokenizer's master side, bound to
// keyword_number_tokenizer_unit. Depends on kntok_pkg.

module kntok_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);
    import kntok_pkg::*;

    // stalled beat stays up
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // eof is always the final token of its input beat
    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == TK_EOF |-> m_tlast)
        else $error("eof token without tlast");

    // operator character only travels with operator tokens
    a_op_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != TK_OPERATOR |-> m_tdata[7:0] == 8'h00)
        else $error("operator_char set on non-operator token");

    // line numbers start at one and saturate, never zero
    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:8] != 16'h0000)
        else $error("start_line is zero");

endmodule

bind keyword_number_tokenizer_unit kntok_checker u_kntok_checker (.*);

FILE: test/tb_top.sv
// tb_top: self-checking testbench for keyword_number_tokenizer_unit, one character beat in,
// token beats out, checked against a cycle-free lexer predictor kept in this file.
// Depends on kntok_pkg for the token kind and lexer mode enums and the result struct.

module tb_top;
    import kntok_pkg::*;

    // no accept on either side for this many cycles means the block hung, even in
    // the 84 percent stall phases
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 560;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } src_beat_t;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        logic       typed;  // want holds the single expected token
        tok_res_t   want;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    // side band that travels with the current input beat
    logic        beat_typed = 1'b0;
    tok_res_t    beat_want  = '0;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          burst_left  = 0;
    logic        calm        = 1'b0;
    int          mismatches  = 0;
    int          checked_tokens = 0;
    int          quiet_cycles   = 0;

    always #6 aclk = ~aclk;

    keyword_number_tokenizer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------
    // lexer predictor
    // ------------------------------------------------------------------
    string      kw_words [10] = '{"def", "extern", "if", "then", "else",
                                  "for", "in", "binary", "unary", "let"};

    lex_mode_t  lx_mode;
    logic       lx_point;
    logic       lx_frac;      // a digit has followed the point
    logic [7:0] lx_word [KEYWORD_CHARS];
    int         lx_wlen;
    pos_t       lx_line, lx_col, lx_tok_line, lx_tok_col;

    tok_res_t   step_toks [$];   // tokens caused by the beat being lexed
    tok_res_t   tokens_due [$];  // tokens still owed by the block, oldest first

    function automatic logic letter_ch(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic word_head_ch(input logic [7:0] c);
        return letter_ch(c) || c == CH_UNDERSCORE || c == CH_DOLLAR;
    endfunction

    function automatic logic blank_ch(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic newline_ch(input logic [7:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction

    function automatic void emit(input tok_kind_t kind, input logic [7:0] op,
                                 input pos_t line, input pos_t col);
        tok_res_t r;
        r.kind    = kind;
        r.op_char = op;
        r.line    = line;
        r.column  = col;
        r.last    = 1'b0;
        step_toks.push_back(r);
    endfunction

    function automatic tok_kind_t word_token_kind();
        logic same;
        if (lx_wlen > KEYWORD_CHARS) begin
            return TK_IDENT;
        end
        for (int k = 0; k < 10; k++) begin
            same = (kw_words[k].len() == lx_wlen);
            for (int i = 0; i < lx_wlen && same; i++) begin
                if (kw_words[k][i] != lx_word[i]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                return tok_kind_t'(TK_DEF + k);
            end
        end
        return TK_IDENT;
    endfunction

    // character seen at a token boundary
    function automatic void open_token(input logic [7:0] c);
        lx_mode = MODE_IDLE;
        if (blank_ch(c)) begin
            return;
        end
        lx_tok_line = lx_line;
        lx_tok_col  = lx_col;
        if (word_head_ch(c)) begin
            lx_mode    = MODE_WORD;
            lx_word[0] = c;
            lx_wlen    = 1;
        end else if (digit_ch(c)) begin
            lx_mode  = MODE_NUM_DIGIT;
            lx_point = 1'b0;
            lx_frac  = 1'b0;
        end else if (c == CH_POINT) begin
            lx_mode  = MODE_NUM_POINT;
            lx_point = 1'b1;
            lx_frac  = 1'b0;
        end else if (c == CH_HASH) begin
            lx_mode = MODE_COMMENT;
        end else begin
            emit(TK_OPERATOR, c, lx_line, lx_col);
        end
    endfunction

    function automatic void lex_step(input logic [7:0] c, input logic eoi);
        step_toks.delete();
        if (eoi) begin
            // flush the open token, drop an open comment, then eof
            case (lx_mode)
                MODE_WORD:      emit(word_token_kind(), 8'h00, lx_tok_line, lx_tok_col);
                MODE_NUM_DIGIT: emit(TK_NUMBER, 8'h00, lx_tok_line, lx_tok_col);
                MODE_NUM_POINT: emit(lx_frac ? TK_NUMBER : TK_ERROR, 8'h00,
                                     lx_tok_line, lx_tok_col);
                default: ;
            endcase
            emit(TK_EOF, 8'h00, lx_line, lx_col);
            lx_mode = MODE_IDLE;
        end else begin
            // position moves first, saturating
            if (newline_ch(c)) begin
                if (lx_line != '1) begin
                    lx_line++;
                end
                lx_col = '0;
            end else if (lx_col != '1) begin
                lx_col++;
            end
            case (lx_mode)
                MODE_COMMENT: begin
                    if (newline_ch(c)) begin
                        lx_mode = MODE_IDLE;
                    end
                end
                MODE_WORD: begin
                    if (word_head_ch(c) || digit_ch(c)) begin
                        if (lx_wlen < KEYWORD_CHARS) begin
                            lx_word[lx_wlen] = c;
                        end
                        if (lx_wlen <= KEYWORD_CHARS) begin
                            lx_wlen++;
                        end
                    end else begin
                        emit(word_token_kind(), 8'h00, lx_tok_line, lx_tok_col);
                        open_token(c);
                    end
                end
                MODE_NUM_DIGIT: begin
                    if (digit_ch(c)) begin
                        if (lx_point) begin
                            lx_frac = 1'b1;
                        end
                    end else if (c == CH_POINT && !lx_point) begin
                        lx_point = 1'b1;
                    end else begin
                        // second point or letter: error at the offending char
                        if (c == CH_POINT || letter_ch(c)) begin
                            emit(TK_ERROR, 8'h00, lx_line, lx_col);
                        end else begin
                            emit(TK_NUMBER, 8'h00, lx_tok_line, lx_tok_col);
                        end
                        open_token(c);
                    end
                end
                MODE_NUM_POINT: begin
                    if (digit_ch(c)) begin
                        lx_frac = 1'b1;
                    end else begin
                        if (letter_ch(c)) begin
                            emit(TK_ERROR, 8'h00, lx_line, lx_col);
                        end else begin
                            emit(lx_frac ? TK_NUMBER : TK_ERROR, 8'h00,
                                 lx_tok_line, lx_tok_col);
                        end
                        open_token(c);
                    end
                end
                default: open_token(c);
            endcase
        end
        if (step_toks.size() != 0) begin
            step_toks[step_toks.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want_v);
        mismatches++;
        $display("token %0d: %s got %0h want %0h", checked_tokens, field, got, want_v);
    endtask

    // both channels sampled at the rising edge, input side first so a token
    // is always owed before it can be checked
    always @(posedge aclk) begin
        tok_res_t exp_tok;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                lex_step(s_tdata, s_tuser);
                if (beat_typed) begin
                    tokens_due.push_back(beat_want);
                end else begin
                    foreach (step_toks[i]) begin
                        tokens_due.push_back(step_toks[i]);
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                if (tokens_due.size() == 0) begin
                    report_mismatch("unexpected kind", 16'(m_tuser), '0);
                end else begin
                    exp_tok = tokens_due.pop_front();
                    if (m_tuser !== exp_tok.kind) begin
                        report_mismatch("kind", 16'(m_tuser), 16'(exp_tok.kind));
                    end
                    if (m_tdata[7:0] !== exp_tok.op_char) begin
                        report_mismatch("operator_char", 16'(m_tdata[7:0]),
                                        16'(exp_tok.op_char));
                    end
                    if (m_tdata[23:8] !== exp_tok.line) begin
                        report_mismatch("start_line", m_tdata[23:8], exp_tok.line);
                    end
                    if (m_tdata[39:24] !== exp_tok.column) begin
                        report_mismatch("start_column", m_tdata[39:24], exp_tok.column);
                    end
                    if (m_tlast !== exp_tok.last) begin
                        report_mismatch("last", 16'(m_tlast), 16'(exp_tok.last));
                    end
                end
                checked_tokens++;
            end
            // watchdog
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver, stalls at random unless a calm stretch is running
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    src_beat_t src_q [$];

    function automatic void add_ch(input logic [7:0] c);
        src_beat_t b;
        b.ch  = c;
        b.eoi = 1'b0;
        src_q.push_back(b);
    endfunction

    // end mark with junk in the ignored char
    function automatic void add_end();
        src_beat_t b;
        b.ch  = 8'($urandom_range(255));
        b.eoi = 1'b1;
        src_q.push_back(b);
    endfunction

    function automatic logic [7:0] rand_word_head();
        int r;
        r = $urandom_range(53);
        if (r < 26) begin
            return 8'(int'("A") + r);
        end else if (r < 52) begin
            return 8'(int'("a") + r - 26);
        end else if (r == 52) begin
            return CH_UNDERSCORE;
        end
        return CH_DOLLAR;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(int'("0") + $urandom_range(9));
    endfunction

    function automatic void add_digits(input int lo, input int hi);
        int n;
        n = $urandom_range(hi, lo);
        for (int i = 0; i < n; i++) begin
            add_ch(rand_digit());
        end
    endfunction

    // one source fragment; mostly well-formed tokens butted together or spaced
    function automatic void add_fragment();
        string      ops;
        string      w;
        int         pick, n;
        logic [7:0] b;
        ops  = "+-*/<>=(),;!&|%^~:?{}[]@";
        pick = $urandom_range(99);
        if (pick < 20) begin
            w = kw_words[$urandom_range(9)];
            for (int i = 0; i < w.len(); i++) begin
                add_ch(w[i]);
            end
            if ($urandom_range(1) == 0) begin
                add_ch(CH_SPACE);
            end
        end else if (pick < 35) begin
            // identifiers, a few beyond the keyword buffer
            n = ($urandom_range(7) == 0) ? $urandom_range(10, 7) : $urandom_range(6, 1);
            add_ch(rand_word_head());
            for (int i = 1; i < n; i++) begin
                add_ch(($urandom_range(3) == 0) ? rand_digit() : rand_word_head());
            end
            if ($urandom_range(1) == 0) begin
                add_ch(CH_SPACE);
            end
        end else if (pick < 50) begin
            if ($urandom_range(3) == 0) begin
                add_ch(CH_POINT);
                add_digits(1, 3);
            end else begin
                add_digits(1, 4);
                if ($urandom_range(1) == 0) begin
                    add_ch(CH_POINT);
                    add_digits(0, 3);
                end
            end
            if ($urandom_range(1) == 0) begin
                add_ch(CH_SPACE);
            end
        end else if (pick < 62) begin
            add_ch(ops[$urandom_range(ops.len() - 1)]);
        end else if (pick < 77) begin
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++) begin
                b = 8'($urandom_range(13, 8));
                add_ch((b == 8'd8) ? CH_SPACE : b);
            end
        end else if (pick < 82) begin
            add_ch(CH_HASH);
            n = $urandom_range(8);
            for (int i = 0; i < n; i++) begin
                do b = 8'($urandom_range(255)); while (newline_ch(b));
                add_ch(b);
            end
            add_ch(($urandom_range(1) == 0) ? CH_LF : CH_CR);
        end else if (pick < 86) begin
            add_end();
        end else if (pick < 94) begin
            // malformed numbers
            case ($urandom_range(4))
                0: begin
                    add_digits(1, 2);
                    add_ch(CH_POINT);
                    add_digits(0, 2);
                    add_ch(CH_POINT);
                    add_digits(0, 2);
                end
                1: begin
                    add_digits(1, 3);
                    add_ch(rand_word_head());
                end
                2: begin
                    add_ch(CH_POINT);
                    add_ch(ops[$urandom_range(ops.len() - 1)]);
                end
                3: begin
                    add_ch(CH_POINT);
                    add_digits(1, 2);
                    add_ch(rand_word_head());
                end
                default: begin
                    add_ch(CH_POINT);
                    add_ch(CH_POINT);
                end
            endcase
        end else begin
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++) begin
                add_ch(8'($urandom_range(255)));
            end
        end
    endfunction

    // one input beat; gaps before it at the sender idle rate, none in a calm stretch
    task automatic send_beat(input logic [7:0] ch, input logic eoi, input logic typed,
                             input tok_res_t want);
        if (burst_left > 0) begin
            burst_left--;
        end else if ($urandom_range(99) < 3) begin
            burst_left = $urandom_range(40, 10);
        end
        calm <= (burst_left != 0);
        while (burst_left == 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= ch;
        s_tuser    <= eoi;
        beat_typed <= typed;
        beat_want  <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_queue();
        foreach (src_q[i]) begin
            send_beat(src_q[i].ch, src_q[i].eoi, 1'b0, '0);
        end
    endtask

    // hold the sender off until every owed token has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (tokens_due.size() != 0);
        @(posedge aclk);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        src_q.delete();
        while (src_q.size() < PHASE_ITEMS) begin
            add_fragment();
        end
        send_queue();
        wait_drained();
    endtask

    function automatic dir_row_t mk(input logic [7:0] ch, input logic eoi = 1'b0);
        dir_row_t r;
        r.ch    = ch;
        r.eoi   = eoi;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic dir_row_t mk_want(input logic [7:0] ch, input logic eoi,
                                         input tok_kind_t kind, input logic [7:0] op,
                                         input pos_t line, input pos_t col);
        dir_row_t r;
        r.ch           = ch;
        r.eoi          = eoi;
        r.typed        = 1'b1;
        r.want.kind    = kind;
        r.want.op_char = op;
        r.want.line    = line;
        r.want.column  = col;
        r.want.last    = 1'b1;
        return r;
    endfunction

    dir_row_t dir_table [$];

    initial begin
        lx_mode     = MODE_IDLE;
        lx_point    = 1'b0;
        lx_frac     = 1'b0;
        lx_wlen     = 0;
        lx_line     = 16'd1;
        lx_col      = '0;
        lx_tok_line = 16'd1;
        lx_tok_col  = '0;
        foreach (lx_word[i]) begin
            lx_word[i] = '0;
        end

        // short directed source: eof from reset, extreme bytes, lone point, second
        // point, letter after number, comment, trailing point, keyword, point-first
        dir_table = '{
            mk_want(CH_NUL, 1'b1, TK_EOF, 8'h00, 16'd1, 16'd0),
            mk_want(CH_NUL, 1'b0, TK_OPERATOR, CH_NUL, 16'd1, 16'd1),
            mk_want(8'hFF, 1'b0, TK_OPERATOR, 8'hFF, 16'd1, 16'd2),
            mk(CH_POINT),
            mk_want(CH_TAB, 1'b0, TK_ERROR, 8'h00, 16'd1, 16'd3),
            mk("5"), mk(CH_POINT), mk(CH_POINT), mk("2"), mk("x"),
            mk(CH_HASH), mk(CH_LF),
            mk("7"), mk(CH_POINT), mk(CH_NUL, 1'b1),
            mk("u"), mk("n"), mk("a"), mk("r"), mk("y"),
            mk_want(CH_CR, 1'b0, TK_UNARY, 8'h00, 16'd2, 16'd3),
            mk_want(CH_NUL, 1'b1, TK_EOF, 8'h00, 16'd3, 16'd0),
            mk(CH_POINT), mk("4"), mk(CH_NUL, 1'b1)
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 26;
        rx_idle_pct <= 84;
        foreach (dir_table[i]) begin
            send_beat(dir_table[i].ch, dir_table[i].eoi, dir_table[i].typed,
                      dir_table[i].want);
        end
        wait_drained();

        run_phase(26, 84);
        run_phase(84, 26);
        run_phase(0, 0);

        repeat (8) @(posedge aclk);
        if (tokens_due.size() != 0) begin
            report_mismatch("leftover tokens", 16'(tokens_due.size()), '0);
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
